@@ hw/rtl/blm_pkg.sv @@
// shared types and constants for the battery level monitor
package blm_pkg;

  localparam int SAMPLES    = 20;
  localparam int ADC_BITS   = 12;
  localparam int GAIN_W     = 20;
  localparam int MV_W       = 16;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam int SUM_W  = $clog2(SAMPLES * ((1 << ADC_BITS) - 1) + 1);
  localparam int PROD_W = SUM_W + GAIN_W;
  localparam int X_W    = PROD_W - FRAC_BITS;

  // floor(x / SAMPLES) as (x * RECIP) >> RECIP_SHIFT, exact for x < 2**X_W
  localparam int      RECIP_SHIFT = X_W + $clog2(SAMPLES);
  localparam longint  RECIP       = ((64'd1 << RECIP_SHIFT) + SAMPLES - 1) / SAMPLES;
  localparam int      RECIP_W     = $clog2(RECIP + 1);
  localparam int      QP_W        = X_W + RECIP_W;
  localparam int      Q_W         = QP_W - RECIP_SHIFT;
  localparam int      QE_W        = (Q_W > MV_W) ? Q_W : MV_W + 1;

  typedef logic [ADC_BITS-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [MV_W-1:0]     mv_t;

  typedef enum logic [1:0] {
    LVL_NORMAL   = 2'd0,
    LVL_LOW      = 2'd1,
    LVL_CRITICAL = 2'd2
  } level_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MV_PER_COUNT = 3'd0,
    REG_LOW_THR      = 3'd1,
    REG_CRIT_THR     = 3'd2,
    REG_HYST         = 3'd3,
    REG_CHECK_EN     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic fill;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    mv_t  low;
    mv_t  crit;
    mv_t  hyst;
    logic check_en;
  } thr_t;

  typedef struct packed {
    logic load;
    logic first;
  } lvl_ctl_t;

endpackage

@@ hw/rtl/blm_cell.sv @@
// one sample cell of the averaging shift chain
module blm_cell import blm_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  sample_t   prev,
  input  sample_t   fill_value,
  output sample_t   value
);

  always_ff @(posedge clk) begin
    if (ctl.fill) begin
      value <= fill_value;
    end else if (ctl.shift) begin
      value <= prev;
    end
  end

endmodule

@@ hw/rtl/blm_level.sv @@
// final stage: saturation, hysteresis classifier and result register
module blm_level import blm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  lvl_ctl_t        ctl,
  input  logic [QP_W-1:0] qprod,
  input  thr_t            thr,
  output mv_t             voltage_mv,
  output level_t          level,
  output logic            level_changed
);

  level_t             level_state;
  level_t             level_next;
  level_t             direct;
  logic [Q_W-1:0]     quot;
  logic [QE_W-1:0]    quot_ext;
  mv_t                volt;
  logic               lt_crit;
  logic               lt_low;
  logic               gt_low_h;
  logic               gt_crit_h;

  assign quot     = qprod[QP_W-1:RECIP_SHIFT];
  assign quot_ext = QE_W'(quot);
  assign volt     = (quot_ext > QE_W'({MV_W{1'b1}})) ? {MV_W{1'b1}} : quot_ext[MV_W-1:0];

  assign lt_crit   = volt < thr.crit;
  assign lt_low    = volt < thr.low;
  assign gt_low_h  = {1'b0, volt} > ({1'b0, thr.low} + {1'b0, thr.hyst});
  assign gt_crit_h = {1'b0, volt} > ({1'b0, thr.crit} + {1'b0, thr.hyst});

  always_comb begin
    if (lt_crit) begin
      direct = LVL_CRITICAL;
    end else if (lt_low) begin
      direct = LVL_LOW;
    end else begin
      direct = LVL_NORMAL;
    end
  end

  always_comb begin
    level_next = direct;
    if (!thr.check_en) begin
      level_next = LVL_NORMAL;
    end else if (!ctl.first) begin
      unique case (level_state)
        LVL_NORMAL: level_next = direct;
        LVL_LOW: begin
          if (lt_crit) begin
            level_next = LVL_CRITICAL;
          end else if (gt_low_h) begin
            level_next = LVL_NORMAL;
          end else begin
            level_next = LVL_LOW;
          end
        end
        LVL_CRITICAL: level_next = gt_crit_h ? LVL_LOW : LVL_CRITICAL;
        default: level_next = direct;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_state <= LVL_NORMAL;
    end else if (ctl.load) begin
      level_state <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      voltage_mv    <= volt;
      level         <= level_next;
      level_changed <= level_next != level_state;
    end
  end

endmodule

@@ hw/rtl/battery_level_monitor_hysteresis.sv @@
// battery level monitor top level: sample chain, running sum, scaling and classifier
//
//   port group     dir  payload (low bit first)                  transfer when
//   s_*            in   tdata: adc_sample[11:0], zero pad         s_tvalid & s_tready
//   m_*            out  tdata: voltage_mv[15:0], level[17:16],    m_tvalid & m_tready
//                             level_changed[18], zero pad
//   cfg_*          in   cfg_addr register index, cfg_data value   cfg_we
//
// one sample accepted per cycle while s_tready is high; its result reaches m_* through
// four register stages: sum, gain multiply, reciprocal multiply, classify and output register
// the sample chain shifts one cell per accepted sample; the first sample fills every cell
// reset clears the pipeline, the first-sample flag and the level to normal
// a stalled output holds; empty stages ahead of it still let samples in
module battery_level_monitor_hysteresis import blm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // adc_sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // voltage_mv, level, level_changed
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic [GAIN_W-1:0] mv_per_count;
  thr_t              thr;

  sample_t           sample;
  sample_t           cell_q [SAMPLES];
  cell_ctl_t         cell_ctl;
  logic              primed;
  logic              accept;

  sum_t              running_sum;
  sum_t              sum_next;
  logic [PROD_W-1:0] prod;
  logic [QP_W-1:0]   qprod;
  logic [X_W-1:0]    xval;
  logic              v1, v2, v3, v4;
  logic              first1, first2, first3;
  logic              en1, en2, en3, en4;
  lvl_ctl_t          lvl_ctl;
  mv_t               voltage_mv;
  level_t            level;
  logic              level_changed;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mv_per_count <= GAIN_W'(195409);
      thr.low      <= MV_W'(10500);
      thr.crit     <= MV_W'(9900);
      thr.hyst     <= MV_W'(200);
      thr.check_en <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MV_PER_COUNT: mv_per_count <= cfg_data[GAIN_W-1:0];
        REG_LOW_THR:      thr.low      <= cfg_data[MV_W-1:0];
        REG_CRIT_THR:     thr.crit     <= cfg_data[MV_W-1:0];
        REG_HYST:         thr.hyst     <= cfg_data[MV_W-1:0];
        REG_CHECK_EN:     thr.check_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline advance, each stage moves when the one ahead is empty or moving
  assign en4      = !v4 || m_tready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign accept   = s_tvalid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // sample chain
  assign sample         = s_tdata[ADC_BITS-1:0];
  assign cell_ctl.fill  = accept && !primed;
  assign cell_ctl.shift = accept && primed;

  for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
    if (i == 0) begin : g_head
      blm_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl),
        .prev       (sample),
        .fill_value (sample),
        .value      (cell_q[i])
      );
    end else begin : g_body
      blm_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl),
        .prev       (cell_q[i-1]),
        .fill_value (sample),
        .value      (cell_q[i])
      );
    end
  end

  // running sum; also the first pipeline stage
  assign sum_next = primed ? (running_sum - SUM_W'(cell_q[SAMPLES-1]) + SUM_W'(sample))
                           : (SUM_W'(sample) * SUM_W'(SAMPLES));

  always_ff @(posedge clk) begin
    if (rst) begin
      primed      <= 1'b0;
      running_sum <= '0;
    end else if (accept) begin
      primed      <= 1'b1;
      running_sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) first1 <= !primed;
  end

  // gain multiply
  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      prod   <= PROD_W'(running_sum) * PROD_W'(mv_per_count);
      first2 <= first1;
    end
  end

  // divide by the sample count through a reciprocal multiply
  assign xval = prod[PROD_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      qprod  <= QP_W'(xval) * QP_W'(RECIP_C);
      first3 <= first2;
    end
  end

  assign lvl_ctl.load  = en4 && v3;
  assign lvl_ctl.first = first3;

  blm_level u_level (
    .clk           (clk),
    .rst           (rst),
    .ctl           (lvl_ctl),
    .qprod         (qprod),
    .thr           (thr),
    .voltage_mv    (voltage_mv),
    .level         (level),
    .level_changed (level_changed)
  );

  assign m_tvalid = v4;
  assign m_tdata  = {{(OUT_DATA_W - MV_W - 3){1'b0}}, level_changed, level, voltage_mv};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> s_tready)
    else $error("input stalled with an empty first stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted sample did not enter the pipeline");

  a_primed_sticks: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("first-sample flag cleared without reset");

  a_fill_once: assert property (@(posedge clk) disable iff (rst)
    (accept && !primed) |=> (primed && first1))
    else $error("first sample did not mark the pipeline");

endmodule

@@ verif/battery_level_monitor_hysteresis_test.sv @@
// testbench for the battery level monitor: sample streams and register phases against a local model
`timescale 1ns / 100ps

module battery_level_monitor_hysteresis_test import blm_pkg::*;;

  localparam int QUIET_LIMIT    = 2000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int ADC_MAX        = (1 << ADC_BITS) - 1;

  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct {
    mv_t    mv;
    level_t level;
    logic   changed;
  } reading_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  battery_level_monitor_hysteresis dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  // register mirror
  logic [GAIN_W-1:0] gain_q16  = 20'd195409;
  mv_t               low_mv    = 16'd10500;
  mv_t               crit_mv   = 16'd9900;
  mv_t               hyst_mv   = 16'd200;
  logic              check_on  = 1'b1;

  // filter and classifier state
  sample_t ring [SAMPLES];
  int      ring_pos  = 0;
  sum_t    ring_sum  = '0;
  bit      primed    = 1'b0;
  level_t  cur_level = LVL_NORMAL;

  reading_t pending_readings [$];
  int       mismatches   = 0;
  int       results_seen = 0;
  bit       tx_gaps      = 1'b1;
  bit       rx_gaps      = 1'b1;
  int       rx_hold_requests = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic reading_t filter_and_classify(sample_t s);
    reading_t        r;
    longint unsigned scaled;
    int              v;
    bit              first;
    level_t          nxt;
    first = !primed;
    if (first) begin
      for (int i = 0; i < SAMPLES; i++) ring[i] = s;
      ring_sum = sum_t'(s) * sum_t'(SAMPLES);
      ring_pos = 0;
      primed   = 1'b1;
    end else begin
      ring_sum = ring_sum - ring[ring_pos] + s;
      ring[ring_pos] = s;
      ring_pos = (ring_pos + 1 >= SAMPLES) ? 0 : ring_pos + 1;
    end
    scaled = (longint'(ring_sum) * longint'(gain_q16)) / (SAMPLES * 65536);
    v = (scaled > 65535) ? 65535 : int'(scaled);
    if (!check_on) begin
      nxt = LVL_NORMAL;
    end else if (first || cur_level == LVL_NORMAL) begin
      if (v < int'(crit_mv)) nxt = LVL_CRITICAL;
      else if (v < int'(low_mv)) nxt = LVL_LOW;
      else nxt = LVL_NORMAL;
    end else if (cur_level == LVL_LOW) begin
      if (v < int'(crit_mv)) nxt = LVL_CRITICAL;
      else if (v > int'(low_mv) + int'(hyst_mv)) nxt = LVL_NORMAL;
      else nxt = LVL_LOW;
    end else begin
      if (v > int'(crit_mv) + int'(hyst_mv)) nxt = LVL_LOW;
      else nxt = LVL_CRITICAL;
    end
    r.mv      = mv_t'(v);
    r.level   = nxt;
    r.changed = (nxt != cur_level);
    cur_level = nxt;
    return r;
  endfunction

  function automatic void store_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    case (addr)
      REG_MV_PER_COUNT: gain_q16 = data[GAIN_W-1:0];
      REG_LOW_THR:      low_mv   = data[MV_W-1:0];
      REG_CRIT_THR:     crit_mv  = data[MV_W-1:0];
      REG_HYST:         hyst_mv  = data[MV_W-1:0];
      REG_CHECK_EN:     check_on = data[0];
      default: ;
    endcase
  endfunction

  function automatic sample_t mv_to_sample(int mv);
    longint cnt;
    if (mv <= 0) return '0;
    if (gain_q16 == 0) return sample_t'($urandom);
    cnt = (longint'(mv) * 65536) / longint'(gain_q16);
    return (cnt > ADC_MAX) ? sample_t'(ADC_MAX) : sample_t'(cnt);
  endfunction

  function automatic int pick_target();
    int t;
    case ($urandom_range(3))
      0: t = int'(crit_mv);
      1: t = int'(low_mv);
      2: t = int'(crit_mv) + int'(hyst_mv);
      default: t = int'(low_mv) + int'(hyst_mv);
    endcase
    return t + int'($urandom_range(0, 600)) - 300;
  endfunction

  function automatic sample_t jitter(sample_t base);
    int x;
    x = int'(base) + int'($urandom_range(0, 8)) - 4;
    if (x < 0) x = 0;
    if (x > ADC_MAX) x = ADC_MAX;
    return sample_t'(x);
  endfunction

  task automatic send_sample(input sample_t s);
    while (tx_gaps && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'(s);
    do @(posedge clk); while (!s_tready);
    pending_readings.push_back(filter_and_classify(s));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    store_reg(addr, data);
  endtask

  // upper data bits are random so the register width masking gets exercised
  task automatic apply_config(input logic [GAIN_W-1:0] g, input mv_t lo, input mv_t cr,
                              input mv_t hy, input logic en);
    drain_results();
    write_reg(REG_MV_PER_COUNT, CFG_DATA_W'(g));
    write_reg(REG_LOW_THR,  {4'($urandom), lo});
    write_reg(REG_CRIT_THR, {4'($urandom), cr});
    write_reg(REG_HYST,     {4'($urandom), hy});
    write_reg(REG_CHECK_EN, {19'($urandom), en});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_random_config(input logic en);
    longint g, vmax, cr, lo;
    g    = $urandom_range(131072, 1048575);
    vmax = (ADC_MAX * g) / 65536;
    cr   = $urandom_range(0, int'(vmax));
    lo   = cr + $urandom_range(0, int'(vmax / 3));
    if (lo > 65535) lo = 65535;
    apply_config(GAIN_W'(g), mv_t'(lo), mv_t'(cr), mv_t'($urandom_range(0, int'(vmax / 16))), en);
  endtask

  // runs of samples parked near a threshold move the mean across it; some noise in between
  task automatic run_mixed(input int items);
    int      done;
    int      len;
    sample_t base;
    done = 0;
    while (done < items) begin
      if ($urandom_range(99) < 15) begin
        send_sample(sample_t'($urandom));
        done++;
      end else begin
        base = mv_to_sample(pick_target());
        len  = $urandom_range(3, 30);
        for (int k = 0; k < len; k++) send_sample(jitter(base));
        done += len;
      end
    end
  endtask

  task automatic test_priming();
    // first sample fills the whole ring and lands in the low band directly
    for (int k = 0; k < 4; k++) send_sample(sample_t'(3400));
  endtask

  task automatic test_extremes();
    sample_t pattern [20] = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h000, 12'h000,
                              12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                              12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                              12'h001, 12'h800};
    foreach (pattern[i]) send_sample(pattern[i]);
  endtask

  task automatic test_config_sweep();
    apply_config(20'd195409, 16'd10500, 16'd9900, 16'd200, 1'b1);
    run_mixed(150);
    apply_config(20'hFFFFF, 16'd40000, 16'd20000, 16'd0, 1'b1);
    run_mixed(150);
    apply_config(20'd0, 16'd5000, 16'd3000, 16'd100, 1'b1);
    run_mixed(60);
    apply_config(20'd1, 16'd0, 16'd0, 16'd0, 1'b1);
    run_mixed(60);
    // critical threshold above the low threshold
    apply_config(20'd300000, 16'd12000, 16'd15000, 16'd500, 1'b1);
    run_mixed(150);
    apply_config(20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    run_mixed(60);
    apply_config(20'hFFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
    run_mixed(60);
    repeat (4) begin
      apply_random_config(1'b1);
      run_mixed(120);
    end
  endtask

  task automatic test_unmapped_registers();
    drain_results();
    write_reg(REG_UNMAPPED_LO, CFG_DATA_W'($urandom));
    write_reg(REG_UNMAPPED_HI, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    run_mixed(60);
  endtask

  task automatic test_check_disabled();
    apply_random_config(1'b1);
    run_mixed(60);
    apply_random_config(1'b0);
    run_mixed(100);
  endtask

  task automatic test_backpressure();
    apply_random_config(1'b1);
    tx_gaps = 1'b0;
    rx_hold_requests++;
    run_mixed(80);
    tx_gaps = 1'b1;
    drain_results();
  endtask

  task automatic test_steady_stream();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_mixed(120);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch in %s of result %0d: expected %0d, got %0d",
               field, results_seen, want, got);
  endtask

  initial begin : rx_driver
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    forever begin
      @(posedge clk);
      if (served != rx_hold_requests) begin
        served    = rx_hold_requests;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(rx_gaps && $urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk) begin : check_results
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_readings.size() == 0) begin
        note_mismatch("transfer with nothing pending", 0, 1);
      end else begin
        want = pending_readings.pop_front();
        if (m_tdata[MV_W-1:0] !== want.mv)
          note_mismatch("voltage_mv", want.mv, m_tdata[MV_W-1:0]);
        if (m_tdata[MV_W+1:MV_W] !== want.level)
          note_mismatch("level", want.level, m_tdata[MV_W+1:MV_W]);
        if (m_tdata[MV_W+2] !== want.changed)
          note_mismatch("level_changed", want.changed, m_tdata[MV_W+2]);
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_priming();
    test_extremes();
    test_config_sweep();
    test_unmapped_registers();
    test_check_disabled();
    test_backpressure();
    test_steady_stream();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/blm_pkg.sv
hw/rtl/blm_cell.sv
hw/rtl/blm_level.sv
hw/rtl/battery_level_monitor_hysteresis.sv
verif/battery_level_monitor_hysteresis_test.sv
